/* design/tbec_pkg.sv */
// Shared types, widths and helpers for the TDC code-density calibration block.
package tbec_pkg;

  localparam int unsigned MAX_IN_BINS = 256;
  localparam int unsigned IDX_W       = $clog2(MAX_IN_BINS);
  localparam int unsigned CNT_W       = 40;
  localparam int unsigned TOT_W       = 48;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned BIN_W       = 9;
  localparam int unsigned EV_W        = 32;
  localparam int unsigned NUM_W       = CNT_W + BIN_W;
  localparam int unsigned DVD_W       = NUM_W + FRAC_W;
  localparam int unsigned DVS_W       = NUM_W;
  localparam int unsigned QUO_W       = 2 * FRAC_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(DVD_W + 1);
  localparam int unsigned SIZE_W      = BIN_W + FRAC_W;
  localparam int unsigned POS_W       = SIZE_W + 1;
  localparam int unsigned FAC_W       = FRAC_W + 1;
  localparam int unsigned K_W         = BIN_W + 1;
  localparam int unsigned CM_W        = 3;
  localparam int unsigned Q8_W        = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned STAT_W      = 3;

  localparam logic [CM_W-1:0]      CM_MAX = CM_W'(4);
  localparam logic [FAC_W-1:0]     ONE_FX = FAC_W'(1) << FRAC_W;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_IN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OUT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ACCUM   = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_EVENTS = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_TOO_FEW   = 3'd3,
    ST_BIN_LARGE = 3'd4
  } status_e;

  typedef struct packed {
    logic [BIN_W-1:0] first_bin;
    logic [CM_W-1:0]  commits;
    logic [FAC_W-1:0] f0;
    logic [FAC_W-1:0] f1;
    logic [FAC_W-1:0] f2;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // floor(f*256), saturating at 255
  function automatic logic [Q8_W-1:0] quant8(input logic [FAC_W-1:0] f);
    logic [FAC_W-1:0] s;
    s = f >> (FRAC_W - Q8_W);
    return (s > FAC_W'(255)) ? Q8_W'(255) : s[Q8_W-1:0];
  endfunction

endpackage

/* design/tbec_if.sv */
// Valid/ready channel interfaces: input items, results and register writes.
interface tbec_item_if;
  logic                            valid;
  logic                            ready;
  tbec_pkg::action_e               action;
  logic [tbec_pkg::IDX_W-1:0]      code_index;
  logic [tbec_pkg::EV_W-1:0]       event_count;
  modport source (output valid, action, code_index, event_count, input ready);
  modport sink   (input valid, action, code_index, event_count, output ready);
endinterface

interface tbec_result_if;
  logic                            valid;
  logic                            ready;
  tbec_pkg::status_e               status;
  logic [tbec_pkg::IDX_W-1:0]      entry_index;
  logic [tbec_pkg::BIN_W-1:0]      first_output_bin;
  logic [tbec_pkg::CM_W-1:0]       commit_count;
  logic [tbec_pkg::Q8_W-1:0]       factor_first;
  logic [tbec_pkg::Q8_W-1:0]       factor_middle;
  logic [tbec_pkg::Q8_W-1:0]       factor_last;
  logic                            table_valid;
  modport source (output valid, status, entry_index, first_output_bin, commit_count,
                  factor_first, factor_middle, factor_last, table_valid, input ready);
  modport sink   (input valid, status, entry_index, first_output_bin, commit_count,
                  factor_first, factor_middle, factor_last, table_valid, output ready);
endinterface

interface tbec_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbec_pkg::CFG_IDX_W-1:0]    index;
  logic [tbec_pkg::BIN_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/tdc_bin_equalizer_calibration.sv */
// Top level: TDC code-density calibration, count store, table build and entry read.
//
//  channel   dir  role     payload
//  item_i    in   sink     action, code_index, event_count
//  result_o  out  source   status, entry_index, first_output_bin, commit_count,
//                          factor_first/middle/last, table_valid
//  cfg_i     in   sink     index (0 input bins, 1 output bins), data
//
// Clear and read go straight to the entry read and response; accumulate first reads the
// count RAM, adds and writes back. Compute walks the codes in use: it totals them, then per
// code does a count read, a multiply, a check, a write and a serial division for the
// size; a code that crosses a boundary adds two more divisions and steps through each
// boundary before it leaves. No events instead writes 256 identity rows.
// No clearing pass after reset: count valid bits reset at once. The next item
// is taken while a result still waits in the output register.
module tdc_bin_equalizer_calibration (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbec_item_if.sink   item_i,
  tbec_result_if.source result_o,
  tbec_cfg_if.sink    cfg_i
);
  import tbec_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ACC, S_SUM_RD, S_SUM_ADD, S_NOEV, S_C_RD, S_C_MUL, S_D1S, S_D1W,
    S_CHK, S_D2S, S_D2W, S_D3S, S_D3W, S_STEP, S_WR, S_POST, S_FX_RD, S_FX_CHK,
    S_LS_RD, S_LS_WR, S_RSP_RD, S_RSP
  } state_e;

  localparam logic [DVD_W-1:0] DVD_ONE_SQ = DVD_W'(1) << (2 * FRAC_W);

  state_e           state_q;
  logic [BIN_W-1:0] nib_q, nob_q, nib_c, nob_c, nib_m1;
  logic [IDX_W-1:0] idx_q;
  logic [EV_W-1:0]  ev_q;
  logic [BIN_W-1:0] i_q;
  logic [TOT_W-1:0] tot_q;
  logic [NUM_W-1:0] prod_q;
  logic [SIZE_W-1:0] size_q;
  logic [POS_W-1:0] pos_q, limit_q, end_pos;
  logic [K_W-1:0]   nb_q, k_q, cmt_q;
  logic [FAC_W-1:0] rest_q, f0_q, f1_q, d0_q, dm_q, fac_raw, fac;
  logic             big_q;
  status_e          st_q, last_st_q;
  logic             tvalid_q;

  // count store: RAM plus one valid bit per code
  logic [CNT_W-1:0]       cnt_mem [MAX_IN_BINS];
  logic [MAX_IN_BINS-1:0] cnt_vld_q;
  logic [CNT_W-1:0]       cnt_rd_q, cnt_eff;
  logic                   cnt_rv_q;
  logic                   cnt_re, cnt_we, cnt_clr;
  logic [IDX_W-1:0]       cnt_raddr;
  logic [CNT_W-1:0]       cnt_wdata;
  logic [CNT_W:0]         acc_sum;
  logic [TOT_W:0]         tot_sum;
  logic [TOT_W-1:0]       tot_sat;

  // table store
  entry_t           ent_mem [MAX_IN_BINS];
  entry_t           ent_rd_q, ent_wdata;
  logic             ent_re, ent_we;
  logic [IDX_W-1:0] ent_raddr, ent_waddr;

  // divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  div_stat_t        div_stat;
  logic [QUO_W-1:0] div_quo;
  logic [FAC_W-1:0] quo_sat;
  logic [POS_W-1:0] gap;

  // output register
  logic             out_vld_q;
  status_e          out_st_q;
  logic [IDX_W-1:0] out_idx_q;
  entry_t           out_ent_q;
  logic             out_tv_q;

  logic [CM_W-1:0]  cm_capped, cm_last;
  logic [CM_W:0]    cm_inc;
  logic             crossing;

  tbec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // register values are clamped when used
  assign nib_c  = (nib_q < BIN_W'(2)) ? BIN_W'(2) :
                  (nib_q > BIN_W'(MAX_IN_BINS)) ? BIN_W'(MAX_IN_BINS) : nib_q;
  assign nob_c  = (nob_q == '0) ? BIN_W'(1) : (nob_q > BIN_W'(256)) ? BIN_W'(256) : nob_q;
  assign nib_m1 = nib_c - BIN_W'(1);

  assign cnt_eff = cnt_rv_q ? cnt_rd_q : '0;
  assign acc_sum = {1'b0, cnt_eff} + (CNT_W+1)'(ev_q);
  assign cnt_wdata = acc_sum[CNT_W] ? '1 : acc_sum[CNT_W-1:0];
  assign tot_sum = {1'b0, tot_q} + (TOT_W+1)'(cnt_eff);
  assign tot_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];

  assign end_pos  = pos_q + POS_W'(size_q);
  assign crossing = end_pos > limit_q;
  assign fac_raw  = (k_q == '0) ? d0_q : dm_q;
  assign fac      = (fac_raw > rest_q) ? rest_q : fac_raw;
  assign gap      = limit_q - pos_q;
  assign quo_sat  = (|div_quo[QUO_W-1:FAC_W]) ? '1 : div_quo[FAC_W-1:0];

  assign cm_capped = (k_q > K_W'(CM_MAX)) ? CM_MAX : k_q[CM_W-1:0];
  assign cm_inc    = {1'b0, ent_rd_q.commits} + (CM_W+1)'(1);
  assign cm_last   = (cm_inc > (CM_W+1)'(CM_MAX)) ? CM_MAX : cm_inc[CM_W-1:0];

  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    cnt_re    = 1'b0;
    cnt_we    = 1'b0;
    cnt_clr   = 1'b0;
    cnt_raddr = i_q[IDX_W-1:0];
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_raddr = idx_q;
    ent_waddr = i_q[IDX_W-1:0];
    ent_wdata = ent_rd_q;
    div_start = 1'b0;
    div_dvd   = DVD_ONE_SQ;
    div_dvs   = DVS_W'(size_q);
    case (state_q)
      S_IDLE: begin
        cnt_raddr = item_i.code_index;
        if (item_i.valid) begin
          cnt_re  = (item_i.action == ACT_ACCUM);
          cnt_clr = (item_i.action == ACT_CLEAR);
        end
      end
      S_ACC: begin
        cnt_we = 1'b1;
      end
      S_SUM_RD, S_C_RD: cnt_re = 1'b1;
      S_NOEV: begin
        ent_we    = 1'b1;
        ent_wdata = '{first_bin: BIN_W'(i_q[IDX_W-1:0]), commits: CM_W'(1),
                      f0: ONE_FX, f1: '0, f2: '0};
      end
      S_D1S: begin
        div_start = 1'b1;
        div_dvd   = {prod_q, FRAC_W'(0)};
        div_dvs   = DVS_W'(tot_q);
      end
      S_D2S: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'({gap, FRAC_W'(0)});
      end
      S_D3S: div_start = 1'b1;
      S_WR: begin
        ent_we    = 1'b1;
        ent_wdata = '{first_bin: nb_q[BIN_W-1:0], commits: cm_capped,
                      f0: f0_q, f1: f1_q, f2: rest_q};
      end
      S_FX_RD: begin
        ent_re    = 1'b1;
        ent_raddr = i_q[IDX_W-1:0];
      end
      S_FX_CHK: begin
        // highest code above 0 with a commit gives one back
        ent_waddr = i_q[IDX_W-1:0];
        ent_we    = (ent_rd_q.commits != '0);
        ent_wdata.commits = ent_rd_q.commits - CM_W'(1);
        ent_wdata.f2      = ent_rd_q.f2 + ent_rd_q.f1;
        ent_wdata.f1      = '0;
      end
      S_LS_RD: begin
        ent_re    = 1'b1;
        ent_raddr = nib_m1[IDX_W-1:0];
      end
      S_LS_WR: begin
        ent_we    = 1'b1;
        ent_waddr = nib_m1[IDX_W-1:0];
        if (ent_rd_q.commits != '0) begin
          ent_wdata.f1 = ent_rd_q.f1 + ent_rd_q.f2;
        end else begin
          ent_wdata.f0 = ONE_FX;
        end
        ent_wdata.f2      = '0;
        ent_wdata.commits = cm_last;
      end
      S_RSP_RD: ent_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[idx_q] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      cnt_rv_q  <= 1'b0;
    end else begin
      if (cnt_re) begin
        cnt_rv_q <= cnt_vld_q[cnt_raddr];
      end
      if (cnt_clr) begin
        cnt_vld_q <= '0;
      end else if (cnt_we) begin
        cnt_vld_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nib_q     <= BIN_W'(128);
      nob_q     <= BIN_W'(128);
      idx_q     <= '0;
      ev_q      <= '0;
      i_q       <= '0;
      tot_q     <= '0;
      prod_q    <= '0;
      size_q    <= '0;
      pos_q     <= '0;
      limit_q   <= '0;
      nb_q      <= '0;
      k_q       <= '0;
      cmt_q     <= '0;
      rest_q    <= '0;
      f0_q      <= '0;
      f1_q      <= '0;
      d0_q      <= '0;
      dm_q      <= '0;
      big_q     <= 1'b0;
      st_q      <= ST_OK;
      last_st_q <= ST_OK;
      tvalid_q  <= 1'b0;
      out_vld_q <= 1'b0;
      out_st_q  <= ST_OK;
      out_idx_q <= '0;
      out_ent_q <= '0;
      out_tv_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == REG_NUM_IN) begin
          nib_q <= cfg_i.data;
        end else if (cfg_i.index == REG_NUM_OUT) begin
          nob_q <= cfg_i.data;
        end
      end
      // output register empties on hand-off; S_RSP refills it itself
      if (out_vld_q && result_o.ready && state_q != S_RSP) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (item_i.valid) begin
            idx_q <= item_i.code_index;
            ev_q  <= item_i.event_count;
            case (item_i.action)
              ACT_ACCUM:   state_q <= S_ACC;
              ACT_COMPUTE: begin
                i_q     <= '0;
                tot_q   <= '0;
                state_q <= S_SUM_RD;
              end
              default:     state_q <= S_RSP_RD;
            endcase
          end
        end
        S_ACC: state_q <= S_RSP_RD;
        S_SUM_RD: state_q <= S_SUM_ADD;
        S_SUM_ADD: begin
          tot_q <= tot_sat;
          if (i_q + BIN_W'(1) == nib_c) begin
            i_q     <= '0;
            pos_q   <= '0;
            limit_q <= POS_W'(ONE_FX);
            nb_q    <= '0;
            cmt_q   <= '0;
            big_q   <= 1'b0;
            state_q <= (tot_sat == '0) ? S_NOEV : S_C_RD;
          end else begin
            i_q     <= i_q + BIN_W'(1);
            state_q <= S_SUM_RD;
          end
        end
        S_NOEV: begin
          if (i_q == BIN_W'(MAX_IN_BINS - 1)) begin
            last_st_q <= ST_NO_EVENTS;
            tvalid_q  <= 1'b0;
            state_q   <= S_RSP_RD;
          end else begin
            i_q <= i_q + BIN_W'(1);
          end
        end
        S_C_RD: state_q <= S_C_MUL;
        S_C_MUL: begin
          prod_q  <= NUM_W'(cnt_eff) * NUM_W'(nob_c);
          state_q <= S_D1S;
        end
        S_D1S: state_q <= S_D1W;
        S_D1W: begin
          if (div_stat.done) begin
            size_q  <= div_quo[SIZE_W-1:0];
            k_q     <= '0;
            rest_q  <= ONE_FX;
            f0_q    <= '0;
            f1_q    <= '0;
            state_q <= S_CHK;
          end
        end
        S_CHK: state_q <= crossing ? S_D2S : S_WR;
        S_D2S: state_q <= S_D2W;
        S_D2W: begin
          if (div_stat.done) begin
            d0_q    <= quo_sat;
            state_q <= S_D3S;
          end
        end
        S_D3S: state_q <= S_D3W;
        S_D3W: begin
          if (div_stat.done) begin
            dm_q    <= quo_sat;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          // one output bin boundary per cycle; later middle shares overwrite
          if (crossing) begin
            if (k_q == '0) begin
              f0_q <= fac;
            end else begin
              f1_q <= fac;
            end
            rest_q  <= rest_q - fac;
            k_q     <= k_q + K_W'(1);
            limit_q <= limit_q + POS_W'(ONE_FX);
          end else begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          pos_q <= end_pos;
          nb_q  <= nb_q + k_q;
          cmt_q <= cmt_q + k_q;
          if (k_q > K_W'(CM_MAX)) begin
            big_q <= 1'b1;
          end
          if (i_q + BIN_W'(1) == nib_c) begin
            state_q <= S_POST;
          end else begin
            i_q     <= i_q + BIN_W'(1);
            state_q <= S_C_RD;
          end
        end
        S_POST: begin
          if (cmt_q > K_W'(nob_c)) begin
            st_q    <= ST_TOO_MANY;
            state_q <= S_LS_RD;
          end else if (cmt_q + K_W'(1) < K_W'(nob_c)) begin
            st_q    <= ST_TOO_FEW;
            state_q <= S_LS_RD;
          end else if (cmt_q == K_W'(nob_c)) begin
            st_q    <= ST_OK;
            i_q     <= nib_m1;
            state_q <= S_FX_RD;
          end else begin
            st_q    <= ST_OK;
            state_q <= S_LS_RD;
          end
        end
        S_FX_RD: state_q <= S_FX_CHK;
        S_FX_CHK: begin
          if (ent_rd_q.commits != '0 || i_q == BIN_W'(1)) begin
            state_q <= S_LS_RD;
          end else begin
            i_q     <= i_q - BIN_W'(1);
            state_q <= S_FX_RD;
          end
        end
        S_LS_RD: state_q <= S_LS_WR;
        S_LS_WR: begin
          if (st_q == ST_OK && (big_q || cm_inc > (CM_W+1)'(CM_MAX))) begin
            last_st_q <= ST_BIN_LARGE;
            tvalid_q  <= 1'b0;
          end else begin
            last_st_q <= st_q;
            tvalid_q  <= (st_q == ST_OK);
          end
          state_q <= S_RSP_RD;
        end
        S_RSP_RD: state_q <= S_RSP;
        S_RSP: begin
          if (!out_vld_q || result_o.ready) begin
            out_vld_q <= 1'b1;
            out_st_q  <= last_st_q;
            out_idx_q <= idx_q;
            out_ent_q <= ent_rd_q;
            out_tv_q  <= tvalid_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid            = out_vld_q;
  assign result_o.status           = out_st_q;
  assign result_o.entry_index      = out_idx_q;
  assign result_o.first_output_bin = out_ent_q.first_bin;
  assign result_o.commit_count     = out_ent_q.commits;
  assign result_o.factor_first     = quant8(out_ent_q.f0);
  assign result_o.factor_middle    = quant8(out_ent_q.f1);
  assign result_o.factor_last      = quant8(out_ent_q.f2);
  assign result_o.table_valid      = out_tv_q;

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

  a_cm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> ent_wdata.commits <= CM_MAX) else $error("stored commits above four");

  a_share: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we && state_q != S_FX_CHK |->
      ((FAC_W+2)'(ent_wdata.f0) + (FAC_W+2)'(ent_wdata.f1) + (FAC_W+2)'(ent_wdata.f2))
        <= (FAC_W+2)'(ONE_FX)) else $error("split factors exceed one");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready) else $error("second item taken");
`endif

endmodule

/* design/tbec_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module tbec_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tbec_pkg::DVD_W-1:0]    dvd_i,
  input  logic [tbec_pkg::DVS_W-1:0]    dvs_i,
  output tbec_pkg::div_stat_t           stat_o,
  output logic [tbec_pkg::QUO_W-1:0]    quo_o
);
  import tbec_pkg::*;

  logic [DVD_W-1:0]     dvd_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [DVS_W-1:0]     rem_q;
  logic [QUO_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DVS_W:0]       trial, diff;
  logic                 ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      dvd_q  <= dvd_i;
      dvs_q  <= dvs_i;
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= DIV_CNT_W'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = quo_q;

endmodule

/* verif/tb.sv */
// Testbench for the TDC code-density calibration block: directed and random transactions.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbec_pkg::*;

  // Fields of one result transaction
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  entry_index;
    logic [BIN_W-1:0]  first_bin;
    logic [CM_W-1:0]   commits;
    logic [Q8_W-1:0]   fac_first;
    logic [Q8_W-1:0]   fac_middle;
    logic [Q8_W-1:0]   fac_last;
    logic              tab_valid;
  } entry_rd_t;

  localparam longint unsigned UNIT      = 64'd1 << FRAC_W;
  localparam longint unsigned CNT_SAT   = (64'd1 << CNT_W) - 1;
  localparam longint unsigned TOTAL_SAT = (64'd1 << TOT_W) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tbec_item_if   item_ch ();
  tbec_result_if res_ch ();
  tbec_cfg_if    cfg_ch ();

  tdc_bin_equalizer_calibration dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the block's state
  longint unsigned code_cnt [MAX_IN_BINS];
  longint unsigned sum_events;
  int unsigned     tab_first [MAX_IN_BINS];
  int unsigned     tab_commits [MAX_IN_BINS];
  longint unsigned tab_fac [MAX_IN_BINS][3];
  bit              tab_ok;
  int unsigned     cur_status;
  logic [BIN_W-1:0] in_bins_reg;
  logic [BIN_W-1:0] out_bins_reg;

  entry_rd_t pending_entries [$];
  int        n_errors = 0;
  int        n_items = 0;
  bit        calm = 1'b0;     // no idling on either side while set

  function automatic logic [Q8_W-1:0] to_q8(longint unsigned f);
    longint unsigned s;
    s = f >> (FRAC_W - Q8_W);
    return (s > 255) ? Q8_W'(255) : Q8_W'(s);
  endfunction

  function automatic void set_commits(int unsigned i, longint unsigned k, ref bit big);
    if (k > 4) begin
      big = 1'b1;
      k = 4;
    end
    tab_commits[i] = 32'(k);
  endfunction

  // Table build: sizes, spread over output bins, commit correction, last-code fix-up
  function automatic void build_table();
    int unsigned     nib, nob, st;
    int              i;
    longint unsigned total, pos, lim, next_bin, commits, num, sz, npos, k, rest;
    longint unsigned f0, f1, fac;
    bit [79:0]       wide;
    bit              big;
    nib = 32'(in_bins_reg);
    nob = 32'(out_bins_reg);
    st = ST_OK;
    big = 1'b0;
    total = 0; pos = 0; lim = UNIT; next_bin = 0; commits = 0;
    if (nib < 2) nib = 2;
    if (nib > MAX_IN_BINS) nib = MAX_IN_BINS;
    if (nob < 1) nob = 1;
    if (nob > 256) nob = 256;
    for (i = 0; i < nib; i++) begin
      total += code_cnt[i];
      if (total > TOTAL_SAT) total = TOTAL_SAT;
    end
    sum_events = total;
    if (total == 0) begin
      // no events: identity table
      for (i = 0; i < MAX_IN_BINS; i++) begin
        tab_first[i] = i;
        tab_commits[i] = 1;
        tab_fac[i][0] = UNIT;
        tab_fac[i][1] = 0;
        tab_fac[i][2] = 0;
      end
      cur_status = ST_NO_EVENTS;
      tab_ok = 1'b0;
      return;
    end
    for (i = 0; i < nib; i++) begin
      num = code_cnt[i] * nob;
      wide = {16'd0, num} << FRAC_W;
      sz = 64'(wide / {16'd0, total});
      npos = pos; k = 0; rest = UNIT; f0 = 0; f1 = 0;
      tab_first[i] = 32'(next_bin & 64'h1FF);
      while (pos + sz > lim) begin
        fac = (sz != 0) ? ((lim - npos) << FRAC_W) / sz : 0;
        k++;
        npos = lim;
        lim = (next_bin + k + 1) * UNIT;
        if (fac > rest) fac = rest;
        rest -= fac;
        if (k == 1) f0 = fac;
        else f1 = fac;
      end
      pos += sz;
      next_bin += k;
      commits += k;
      tab_fac[i][0] = f0;
      tab_fac[i][1] = f1;
      tab_fac[i][2] = rest;
      set_commits(i, k, big);
    end
    if (commits > nob) st = ST_TOO_MANY;
    else if (commits + 1 < nob) st = ST_TOO_FEW;
    else if (commits == nob) begin
      // exact count: highest code above 0 with a commit gives one back
      for (i = nib - 1; i > 0; i--) begin
        if (tab_commits[i] != 0) begin
          tab_commits[i]--;
          tab_fac[i][2] += tab_fac[i][1];
          tab_fac[i][1] = 0;
          break;
        end
      end
    end
    i = nib - 1;
    if (tab_commits[i] != 0) begin
      tab_fac[i][1] += tab_fac[i][2];
      tab_fac[i][2] = 0;
    end else begin
      tab_fac[i][0] = UNIT;
      tab_fac[i][2] = 0;
    end
    set_commits(i, longint'(tab_commits[i]) + 1, big);
    if (st == ST_OK && big) st = ST_BIN_LARGE;
    cur_status = st;
    tab_ok = (st == ST_OK);
  endfunction

  // Apply one accepted item to the shadow state, return the entry it reads back
  function automatic entry_rd_t apply_item(action_e act, logic [IDX_W-1:0] idx,
                                           logic [EV_W-1:0] ev);
    entry_rd_t e;
    longint unsigned c;
    case (act)
      ACT_CLEAR: begin
        foreach (code_cnt[j]) code_cnt[j] = 0;
        sum_events = 0;
      end
      ACT_ACCUM: begin
        c = code_cnt[idx] + ev;
        code_cnt[idx] = (c > CNT_SAT) ? CNT_SAT : c;
      end
      ACT_COMPUTE: build_table();
      default: ;
    endcase
    e.status      = STAT_W'(cur_status);
    e.entry_index = idx;
    e.first_bin   = BIN_W'(tab_first[idx]);
    e.commits     = CM_W'(tab_commits[idx]);
    e.fac_first   = to_q8(tab_fac[idx][0]);
    e.fac_middle  = to_q8(tab_fac[idx][1]);
    e.fac_last    = to_q8(tab_fac[idx][2]);
    e.tab_valid   = tab_ok;
    return e;
  endfunction

  task automatic idle_gap();
    if (!calm && $urandom_range(99) < 12) begin
      @(negedge clk_i);
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
  endtask

  // Send one item; expectation queued at acceptance
  task automatic send_item(action_e act, logic [IDX_W-1:0] idx, logic [EV_W-1:0] ev);
    idle_gap();
    @(negedge clk_i);
    item_ch.valid       <= 1'b1;
    item_ch.action      <= act;
    item_ch.code_index  <= idx;
    item_ch.event_count <= ev;
    do @(posedge clk_i); while (!item_ch.ready);
    pending_entries = {pending_entries, apply_item(act, idx, ev)};
    n_items++;
  endtask

  // Wait for every expected result, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BIN_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == REG_NUM_IN) in_bins_reg = val;
    else if (idx == REG_NUM_OUT) out_bins_reg = val;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_bins(int unsigned nib, int unsigned nob);
    write_reg(REG_NUM_IN, BIN_W'(nib));
    write_reg(REG_NUM_OUT, BIN_W'(nob));
  endtask

  // Result sink stalls at random
  always @(negedge clk_i) res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Result checker: each transaction against the oldest expectation
  always @(posedge clk_i) begin
    entry_rd_t exp_e;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected result, entry %0d", $time, res_ch.entry_index);
        n_errors++;
      end else begin
        exp_e = pending_entries.pop_front();
        check_field("status", exp_e.status, res_ch.status);
        check_field("entry_index", exp_e.entry_index, res_ch.entry_index);
        check_field("first_output_bin", exp_e.first_bin, res_ch.first_output_bin);
        check_field("commit_count", exp_e.commits, res_ch.commit_count);
        check_field("factor_first", exp_e.fac_first, res_ch.factor_first);
        check_field("factor_middle", exp_e.fac_middle, res_ch.factor_middle);
        check_field("factor_last", exp_e.fac_last, res_ch.factor_last);
        check_field("table_valid", exp_e.tab_valid, res_ch.table_valid);
      end
    end
  end

  // Compute on empty counts first: every entry is written before any read
  task automatic test_no_events();
    send_item(ACT_COMPUTE, 8'd0, 32'd0);
    send_item(ACT_READ, 8'd255, 32'hFFFF_FFFF);
    send_item(ACT_READ, 8'd0, 32'd0);
  endtask

  // Flat histogram one commit short, a code far too large, then clamped registers
  task automatic test_directed();
    int i;
    set_bins(4, 4);
    for (i = 0; i < 4; i++) send_item(ACT_ACCUM, IDX_W'(i), 32'd1000);
    send_item(ACT_COMPUTE, 8'd3, 32'd0);
    send_item(ACT_READ, 8'd0, 32'd0);
    send_item(ACT_CLEAR, 8'd1, 32'd0);
    // bin too large: one code holds everything
    set_bins(2, 16);
    send_item(ACT_ACCUM, 8'd0, 32'hFFFF_FFFF);
    send_item(ACT_COMPUTE, 8'd0, 32'd0);
    send_item(ACT_READ, 8'd1, 32'd0);
    // out-of-range registers are clamped at compute time
    set_bins(0, 0);
    send_item(ACT_ACCUM, 8'd1, 32'd5);
    send_item(ACT_COMPUTE, 8'd1, 32'd0);
    set_bins(511, 511);
    send_item(ACT_ACCUM, 8'd255, 32'h8000_0001);
    send_item(ACT_COMPUTE, 8'd255, 32'd0);
    send_item(ACT_READ, 8'd128, 32'd0);
    send_item(ACT_CLEAR, 8'd0, 32'd0);
    // bin too large again: one code spread over many output bins
    set_bins(8, 200);
    send_item(ACT_ACCUM, 8'd2, 32'd7);
    send_item(ACT_COMPUTE, 8'd7, 32'd0);
    send_item(ACT_CLEAR, 8'd0, 32'd0);
  endtask

  // Count saturation: one code driven past the 40-bit limit
  task automatic test_saturation();
    int i;
    set_bins(16, 8);
    for (i = 0; i < 258; i++) send_item(ACT_ACCUM, 8'd7, 32'hFFFF_FFFF);
    send_item(ACT_ACCUM, 8'd8, 32'd1);
    send_item(ACT_COMPUTE, 8'd7, 32'd0);
    send_item(ACT_READ, 8'd8, 32'd0);
    send_item(ACT_CLEAR, 8'd0, 32'd0);
  endtask

  // Random calibration runs: clear, fill a histogram, compute, read back
  task automatic test_random();
    int unsigned nib, nob, base, shape, n_rd, i;
    logic [EV_W-1:0] ev;
    while (n_items < 900) begin
      if ($urandom_range(7) == 0) nib = 256;
      else nib = $urandom_range(32, 2);
      case ($urandom_range(3))
        0: nob = nib;
        1: nob = $urandom_range(nib, 1);
        2: nob = $urandom_range(256, 1);
        default: nob = $urandom_range(511, 0);
      endcase
      if ($urandom_range(9) == 0) nib = $urandom_range(511, 0);
      set_bins(nib, nob);
      calm = ($urandom_range(4) == 0);
      send_item(ACT_CLEAR, IDX_W'($urandom), 32'($urandom));
      shape = $urandom_range(3);
      base = $urandom_range(5000, 1);
      for (i = 0; i < ((nib > 256) ? 256 : nib); i++) begin
        case (shape)
          0: ev = base + $urandom_range(base / 4);
          1: ev = $urandom;
          2: ev = ($urandom_range(3) == 0) ? $urandom_range(100000) : 0;
          default: ev = $urandom_range(base);
        endcase
        send_item(ACT_ACCUM, IDX_W'(i), ev);
        if ($urandom_range(15) == 0)
          send_item(action_e'($urandom_range(3) | 1), IDX_W'($urandom), 32'($urandom));
      end
      send_item(ACT_COMPUTE, IDX_W'($urandom), 32'($urandom));
      n_rd = $urandom_range(10, 3);
      for (i = 0; i < n_rd; i++)
        send_item(ACT_READ, IDX_W'($urandom_range((nib > 256) ? 255 : nib)), 32'($urandom));
      if ($urandom_range(3) == 0) drain();   // hold off until all results are in
    end
    calm = 1'b0;
  endtask

  initial begin
    foreach (code_cnt[j]) begin
      code_cnt[j] = 0;
      tab_first[j] = 0;
      tab_commits[j] = 0;
      tab_fac[j][0] = 0;
      tab_fac[j][1] = 0;
      tab_fac[j][2] = 0;
    end
    sum_events = 0;
    tab_ok = 1'b0;
    cur_status = ST_OK;
    in_bins_reg = 9'd128;
    out_bins_reg = 9'd128;
    item_ch.valid = 1'b0;
    item_ch.action = ACT_CLEAR;
    item_ch.code_index = '0;
    item_ch.event_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_NUM_IN;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_no_events();
    test_directed();
    test_saturation();
    test_random();
    drain();
    repeat (50) @(posedge clk_i);
    if (n_errors == 0 && pending_entries.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit: far above the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout, %0d results outstanding", pending_entries.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
